/* hw/rtl/kpd_pkg.sv */
// ----------------------------------------------------------------------------
// kpd_pkg: shared types and constants for the keypad scanner
// Key legend table, scan and decode types, debounce reset value.
// ----------------------------------------------------------------------------
package kpd_pkg;

   localparam int NUM_COLS   = 4;
   localparam int NUM_ROWS   = 4;
   localparam int CODE_W     = 8;
   localparam int COUNT_W    = 8;

   localparam logic [COUNT_W-1:0] DEBOUNCE_RESET = 8'd50;

   // one row nibble per driven column
   typedef logic [NUM_ROWS-1:0] rows_type;
   typedef rows_type [NUM_COLS-1:0] scan_type;

   // decoder output
   typedef struct packed {
      logic              pressed;
      logic [CODE_W-1:0] code;
   } decode_type;

   // debounce status towards the top level
   typedef struct packed {
      logic              phase;  // high while waiting for the release
      logic              emit;   // current beat confirms the release
      logic [CODE_W-1:0] key;    // latched key code
   } dbn_status_type;

   // legend, indexed by column + 4 * row
   localparam logic [CODE_W-1:0] KEY_TABLE [16] = '{
      8'h31, 8'h34, 8'h37, 8'h2A, 8'h32, 8'h35, 8'h38, 8'h30,
      8'h33, 8'h36, 8'h39, 8'h23, 8'h41, 8'h42, 8'h43, 8'h44
   };

endpackage

/* hw/rtl/kpd_decode.sv */
// ----------------------------------------------------------------------------
// kpd_decode: key matrix scan decoder
// Picks the lowest active column, the highest row within it, looks up the key.
// ----------------------------------------------------------------------------
module kpd_decode (
   input  kpd_pkg::scan_type   scan,
   output kpd_pkg::decode_type result
);
   import kpd_pkg::*;

   logic [1:0] col;
   logic [1:0] row;
   rows_type   rows;
   logic       pressed;

   // lowest active column wins: walk downwards so the last hit is the lowest
   always_comb begin
      col     = 2'd0;
      rows    = '0;
      pressed = 1'b0;
      for (int c = NUM_COLS - 1; c >= 0; c--) begin
         if (scan[c] != '0) begin
            col     = 2'(c);
            rows    = scan[c];
            pressed = 1'b1;
         end
      end
   end

   // highest set row bit within that column
   always_comb begin
      row = 2'd0;
      for (int r = 0; r < NUM_ROWS; r++) begin
         if (rows[r]) begin
            row = 2'(r);
         end
      end
   end

   assign result.pressed = pressed;
   assign result.code    = KEY_TABLE[{row, col}];

endmodule

/* hw/rtl/kpd_debounce.sv */
// ----------------------------------------------------------------------------
// kpd_debounce: press and release run counter
// Counts consecutive pressed, then released scans; flags the confirming beat.
// ----------------------------------------------------------------------------
module kpd_debounce (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    step,
   input  kpd_pkg::decode_type     scan,
   input  logic [7:0]              debounce_scans,
   output kpd_pkg::dbn_status_type status
);
   import kpd_pkg::*;

   logic               phase_ff, phase_in;
   logic [COUNT_W-1:0] count_ff, count_in;
   logic [CODE_W-1:0]  latch_ff, latch_in;
   logic [COUNT_W:0]   count_next;
   logic [COUNT_W-1:0] need;
   logic               reached;

   // zero threshold behaves as one
   assign need       = (debounce_scans == '0) ? COUNT_W'(1) : debounce_scans;
   assign count_next = {1'b0, count_ff} + (COUNT_W + 1)'(1);
   assign reached    = count_next >= {1'b0, need};

   // next state
   always_comb begin
      phase_in = phase_ff;
      count_in = count_ff;
      latch_in = scan.pressed ? scan.code : latch_ff;
      if (!phase_ff) begin
         if (!scan.pressed) begin
            count_in = '0;
         end else if (reached) begin
            phase_in = 1'b1;
            count_in = '0;
         end else begin
            count_in = count_next[COUNT_W-1:0];
         end
      end else begin
         if (scan.pressed) begin
            count_in = '0;
         end else if (reached) begin
            phase_in = 1'b0;
            count_in = '0;
         end else begin
            count_in = count_next[COUNT_W-1:0];
         end
      end
   end

   // status outputs
   always_comb begin
      status.phase = phase_ff;
      status.emit  = phase_ff && !scan.pressed && reached;
      status.key   = latch_ff;
   end

   // state registers, updated once per consumed beat
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= 1'b0;
         count_ff <= '0;
         latch_ff <= '0;
      end else if (step) begin
         phase_ff <= phase_in;
         count_ff <= count_in;
         latch_ff <= latch_in;
      end
   end

endmodule

/* hw/rtl/keypad_scan_debounce.sv */
// ----------------------------------------------------------------------------
// keypad_scan_debounce: 4x4 keypad scan decoder with press/release debounce
// One beat is one full matrix scan; a key code beat follows a confirmed release.
//
//   channel | direction | handshake          | payload
//   req     | in        | req_valid/ready    | req_rows_col0..3 (4 bit each)
//   rsp     | out       | rsp_valid/ready    | rsp_key_code (8 bit)
//   csr     | in        | csr_wr_en          | csr_wr_data (debounce scans)
//
// One scan per cycle unless a held result stalls an emitting scan; a result is
// offered once its scan has passed the input register, then the result register.
// Reset clears the debounce state and sets the threshold to 50 scans.
// A held result stalls only a scan that would emit; other scans keep flowing.
// ----------------------------------------------------------------------------
module keypad_scan_debounce #(
   parameter logic [7:0] DEBOUNCE_DEFAULT = kpd_pkg::DEBOUNCE_RESET
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [3:0] req_rows_col0,
   input  logic [3:0] req_rows_col1,
   input  logic [3:0] req_rows_col2,
   input  logic [3:0] req_rows_col3,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [7:0] rsp_key_code,
   input  logic       csr_wr_en,
   input  logic [7:0] csr_wr_data
);
   import kpd_pkg::*;

   logic           dbn_ff;
   logic [7:0]     dbn_scans_ff;
   logic           s1_valid_ff, s1_valid_in;
   scan_type       s1_scan_ff;
   logic           rsp_valid_ff, rsp_valid_in;
   logic [7:0]     rsp_key_ff;
   decode_type     dec;
   dbn_status_type status;
   logic           advance;
   logic           out_free;

   // threshold register
   always_ff @(posedge clock) begin
      if (reset) begin
         dbn_scans_ff <= DEBOUNCE_DEFAULT;
         dbn_ff       <= 1'b0;
      end else if (csr_wr_en) begin
         dbn_scans_ff <= csr_wr_data;
         dbn_ff       <= 1'b1;
      end
   end

   // stage control: an emitting beat needs room in the result register
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign advance   = s1_valid_ff && (out_free || !status.emit);
   assign req_ready = !s1_valid_ff || advance;

   assign s1_valid_in  = req_valid || (s1_valid_ff && !advance);
   assign rsp_valid_in = (advance && status.emit) || (rsp_valid_ff && !rsp_ready);

   // input register
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (req_ready) begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         s1_scan_ff <= {req_rows_col3, req_rows_col2, req_rows_col1, req_rows_col0};
      end
   end

   kpd_decode u_decode (
      .scan   (s1_scan_ff),
      .result (dec)
   );

   kpd_debounce u_debounce (
      .clock          (clock),
      .reset          (reset),
      .step           (advance),
      .scan           (dec),
      .debounce_scans (dbn_scans_ff),
      .status         (status)
   );

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance && status.emit) begin
         rsp_key_ff <= status.key;
      end
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_key_code = rsp_key_ff;

   // a release is only confirmed from the release phase on a released scan
   a_emit_phase: assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && status.emit) |-> (status.phase && !dec.pressed))
      else $error("release confirmed outside release phase");

   // an emitting beat lands in the result register with the latched code
   a_emit_load: assert property (@(posedge clock) disable iff (reset)
      (advance && status.emit) |=> (rsp_valid_ff && rsp_key_ff == $past(status.key)))
      else $error("confirmed key not loaded into result register");

   // a blocked emitting beat must not overwrite the pending result
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_ready) |=> (rsp_valid_ff && $stable(rsp_key_ff)))
      else $error("pending result lost or changed");

   // threshold flag is only a write marker; a write keeps its data
   a_csr_write: assert property (@(posedge clock) disable iff (reset)
      csr_wr_en |=> (dbn_ff && dbn_scans_ff == $past(csr_wr_data)))
      else $error("threshold write lost");

endmodule
